>>> src/bufe_pkg.sv
// Shared types and codes for the buffered serial port FIFO engine.
package bufe_pkg;

  // Request function codes.
  localparam logic [2:0] FN_HOST_WR  = 3'd0;
  localparam logic [2:0] FN_HOST_RD  = 3'd1;
  localparam logic [2:0] FN_LINE_RX  = 3'd2;
  localparam logic [2:0] FN_TX_READY = 3'd3;
  localparam logic [2:0] FN_DMA_GO   = 3'd4;
  localparam logic [2:0] FN_DMA_DONE = 3'd5;

  // Result status codes.
  localparam logic [2:0] STS_OK      = 3'd0;
  localparam logic [2:0] STS_BUSY    = 3'd1;
  localparam logic [2:0] STS_FULL    = 3'd2;
  localparam logic [2:0] STS_EMPTY   = 3'd3;
  localparam logic [2:0] STS_INVALID = 3'd4;

  // Event codes.
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_RX_RDY  = 2'd1;
  localparam logic [1:0] EV_ERROR   = 2'd2;
  localparam logic [1:0] EV_TX_DONE = 2'd3;

  // Source of the returned byte.
  localparam logic [1:0] SRC_NONE = 2'd0;
  localparam logic [1:0] SRC_TX   = 2'd1;
  localparam logic [1:0] SRC_RX   = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_valid;
  } sts_t;

endpackage

>>> src/buffered_uart_fifo_engine_core.sv
// Top level of the buffered serial port FIFO engine.
//
// The block keeps the transmit and receive rings of a serial port. Each
// request on the input channel (in_valid/in_ready) carries one event: a host
// write or read, a received line byte, a transmitter-ready tick, a DMA start
// or a DMA completion. Every request yields exactly one result on the output
// channel (out_valid/out_ready), carrying the status, any popped byte, an
// event code and the error counter and flags as they stand after the event.
// The single configuration register, dma_attached, is written through
// cfg_wr_en/cfg_wr_data at any clock edge with no wait state.
// A request's state updates and the ring reads happen at the edge that
// accepts it; the controller then moves to its load state and loads the
// result into the output register as soon as that register is free or
// being taken. The block handles one request at a time and takes no new one
// until the last result has been loaded into the output register.
// When the receiver stalls, the finished result waits in the output register
// and the block still accepts the next request; that request's result then
// waits until the output register is taken. A synchronous active-low reset
// empties both rings, clears the flags, the error counter and dma_attached,
// and leaves no result pending; ring contents are not cleared.
module buffered_uart_fifo_engine_core #(
  parameter int TX_DEPTH = 64,
  parameter int RX_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic [7:0]  in_data_in,
  input  logic [15:0] in_dma_length,
  input  logic        in_dma_refused,
  input  logic        in_dma_ok,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [7:0]  out_data_out,
  output logic        out_line_byte_valid,
  output logic [1:0]  out_event_code,
  output logic [31:0] out_errors_seen,
  output logic        out_tx_draining,
  output logic        out_dma_busy
);
  import bufe_pkg::*;

  // Commands and status between the controller and the datapath.
  cmd_t cmd;
  sts_t sts;

  // The controller decides when a request is taken and when its result is
  // moved into the output register.
  bufe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the rings, the flags, the error counter and the
  // result register.
  bufe_dpath #(
    .TX_DEPTH (TX_DEPTH),
    .RX_DEPTH (RX_DEPTH)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_func             (in_func),
    .in_data_in          (in_data_in),
    .in_dma_length       (in_dma_length),
    .in_dma_refused      (in_dma_refused),
    .in_dma_ok           (in_dma_ok),
    .out_ready           (out_ready),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_data_out        (out_data_out),
    .out_line_byte_valid (out_line_byte_valid),
    .out_event_code      (out_event_code),
    .out_errors_seen     (out_errors_seen),
    .out_tx_draining     (out_tx_draining),
    .out_dma_busy        (out_dma_busy)
  );

endmodule

>>> src/bufe_ctrl.sv
// Controller state machine: request acceptance and result hand-off.
module bufe_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           out_ready,
  input  bufe_pkg::sts_t sts,
  output bufe_pkg::cmd_t cmd
);
  import bufe_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LOAD = 1'b1;

  logic state_r;
  logic state_nxt;

  assign in_ready   = (state_r == S_IDLE);
  assign cmd.accept = in_valid && in_ready;
  assign cmd.load   = (state_r == S_LOAD) && (!sts.out_valid || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.accept) state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (cmd.load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> src/bufe_dpath.sv
// Datapath: both rings, flags, error counter and the result register.
module bufe_dpath #(
  parameter int TX_DEPTH = 64,
  parameter int RX_DEPTH = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  bufe_pkg::cmd_t cmd,
  output bufe_pkg::sts_t sts,
  input  logic           cfg_wr_en,
  input  logic           cfg_wr_data,
  input  logic [2:0]     in_func,
  input  logic [7:0]     in_data_in,
  input  logic [15:0]    in_dma_length,
  input  logic           in_dma_refused,
  input  logic           in_dma_ok,
  input  logic           out_ready,
  output logic           out_valid,
  output logic [2:0]     out_status,
  output logic [7:0]     out_data_out,
  output logic           out_line_byte_valid,
  output logic [1:0]     out_event_code,
  output logic [31:0]    out_errors_seen,
  output logic           out_tx_draining,
  output logic           out_dma_busy
);
  import bufe_pkg::*;

  localparam int TXW = $clog2(TX_DEPTH);
  localparam int RXW = $clog2(RX_DEPTH);
  localparam logic [TXW-1:0] TX_LAST = TXW'(TX_DEPTH - 1);
  localparam logic [RXW-1:0] RX_LAST = RXW'(RX_DEPTH - 1);

  logic [7:0] tx_mem [TX_DEPTH];
  logic [7:0] rx_mem [RX_DEPTH];

  logic [TXW-1:0] tx_wr_r, tx_wr_nxt, tx_rd_r, tx_rd_nxt, tx_wr_inc, tx_rd_inc;
  logic [RXW-1:0] rx_wr_r, rx_wr_nxt, rx_rd_r, rx_rd_nxt, rx_wr_inc, rx_rd_inc;
  logic           drain_r, drain_nxt;
  logic           dma_run_r, dma_run_nxt;
  logic [31:0]    err_r, err_nxt;
  logic           attached_r;
  logic           tx_we, rx_we;
  logic           tx_empty, tx_full, rx_empty, rx_full;

  // Pending result held between acceptance and hand-off.
  logic [2:0] p_status_r, p_status_nxt;
  logic [1:0] p_src_r, p_src_nxt;
  logic       p_line_r, p_line_nxt;
  logic [1:0] p_event_r, p_event_nxt;
  logic [7:0] tx_rdata_r, rx_rdata_r;
  logic [7:0] sel_data;

  logic out_valid_r, out_valid_nxt;

  assign tx_wr_inc = (tx_wr_r == TX_LAST) ? '0 : tx_wr_r + 1'b1;
  assign tx_rd_inc = (tx_rd_r == TX_LAST) ? '0 : tx_rd_r + 1'b1;
  assign rx_wr_inc = (rx_wr_r == RX_LAST) ? '0 : rx_wr_r + 1'b1;
  assign rx_rd_inc = (rx_rd_r == RX_LAST) ? '0 : rx_rd_r + 1'b1;

  assign tx_empty = (tx_wr_r == tx_rd_r);
  assign tx_full  = (tx_wr_inc == tx_rd_r);
  assign rx_empty = (rx_wr_r == rx_rd_r);
  assign rx_full  = (rx_wr_inc == rx_rd_r);

  always_comb begin
    tx_wr_nxt    = tx_wr_r;
    tx_rd_nxt    = tx_rd_r;
    rx_wr_nxt    = rx_wr_r;
    rx_rd_nxt    = rx_rd_r;
    drain_nxt    = drain_r;
    dma_run_nxt  = dma_run_r;
    err_nxt      = err_r;
    tx_we        = 1'b0;
    rx_we        = 1'b0;
    p_status_nxt = STS_OK;
    p_src_nxt    = SRC_NONE;
    p_line_nxt   = 1'b0;
    p_event_nxt  = EV_NONE;
    case (in_func)
      FN_HOST_WR: begin
        if (dma_run_r) begin
          p_status_nxt = STS_BUSY;
        end else if (tx_full) begin
          p_status_nxt = STS_FULL;
        end else begin
          tx_we     = 1'b1;
          tx_wr_nxt = tx_wr_inc;
          drain_nxt = 1'b1;
        end
      end
      FN_HOST_RD: begin
        if (rx_empty) begin
          p_status_nxt = STS_EMPTY;
        end else begin
          p_src_nxt = SRC_RX;
          rx_rd_nxt = rx_rd_inc;
        end
      end
      FN_LINE_RX: begin
        if (!rx_full) begin
          rx_we       = 1'b1;
          rx_wr_nxt   = rx_wr_inc;
          p_event_nxt = EV_RX_RDY;
        end else begin
          err_nxt     = err_r + 32'd1;
          p_event_nxt = EV_ERROR;
        end
      end
      FN_TX_READY: begin
        if (drain_r) begin
          if (!tx_empty) begin
            p_src_nxt  = SRC_TX;
            tx_rd_nxt  = tx_rd_inc;
            p_line_nxt = 1'b1;
          end else begin
            drain_nxt   = 1'b0;
            p_event_nxt = EV_TX_DONE;
          end
        end
      end
      FN_DMA_GO: begin
        if (in_dma_length == 16'd0 || !attached_r) begin
          p_status_nxt = STS_INVALID;
        end else if (dma_run_r || drain_r || !tx_empty) begin
          p_status_nxt = STS_BUSY;
        end else begin
          drain_nxt = 1'b0;
          if (in_dma_refused) begin
            p_status_nxt = STS_BUSY;
          end else begin
            dma_run_nxt = 1'b1;
          end
        end
      end
      FN_DMA_DONE: begin
        dma_run_nxt = 1'b0;
        if (in_dma_ok) begin
          p_event_nxt = EV_TX_DONE;
        end else begin
          err_nxt     = err_r + 32'd1;
          p_event_nxt = EV_ERROR;
        end
      end
      default: p_status_nxt = STS_INVALID;
    endcase
  end

  // Ring storage: one write and one registered read per ring per request.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      if (tx_we) tx_mem[tx_wr_r] <= in_data_in;
      tx_rdata_r <= tx_mem[tx_rd_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      if (rx_we) rx_mem[rx_wr_r] <= in_data_in;
      rx_rdata_r <= rx_mem[rx_rd_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_wr_r    <= '0;
      tx_rd_r    <= '0;
      rx_wr_r    <= '0;
      rx_rd_r    <= '0;
      drain_r    <= 1'b0;
      dma_run_r  <= 1'b0;
      err_r      <= '0;
      attached_r <= 1'b0;
    end else begin
      if (cfg_wr_en) attached_r <= cfg_wr_data;
      if (cmd.accept) begin
        tx_wr_r   <= tx_wr_nxt;
        tx_rd_r   <= tx_rd_nxt;
        rx_wr_r   <= rx_wr_nxt;
        rx_rd_r   <= rx_rd_nxt;
        drain_r   <= drain_nxt;
        dma_run_r <= dma_run_nxt;
        err_r     <= err_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      p_status_r <= p_status_nxt;
      p_src_r    <= p_src_nxt;
      p_line_r   <= p_line_nxt;
      p_event_r  <= p_event_nxt;
    end
  end

  always_comb begin
    case (p_src_r)
      SRC_TX:  sel_data = tx_rdata_r;
      SRC_RX:  sel_data = rx_rdata_r;
      default: sel_data = 8'd0;
    endcase
  end

  // Result register.
  assign out_valid_nxt = cmd.load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_status          <= p_status_r;
      out_data_out        <= sel_data;
      out_line_byte_valid <= p_line_r;
      out_event_code      <= p_event_r;
      out_errors_seen     <= err_r;
      out_tx_draining     <= drain_r;
      out_dma_busy        <= dma_run_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign sts.out_valid = out_valid_r;

endmodule

>>> src/bufe_chk.sv
// Port-level checker for the buffered serial port FIFO engine, with its bind.
module bufe_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [7:0]  out_data_out,
  input logic        out_line_byte_valid,
  input logic [1:0]  out_event_code,
  input logic [31:0] out_errors_seen,
  input logic        out_tx_draining
);
  import bufe_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_status) && $stable(out_data_out)
      && $stable(out_errors_seen))
    else $error("result payload changed while stalled");

  // Requests are taken one at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted in consecutive cycles");

  // A byte sent to the line comes only with an ok status, no event and the transmitter draining.
  a_line_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_line_byte_valid |-> out_status == STS_OK &&
      out_event_code == EV_NONE && out_tx_draining)
    else $error("line byte with inconsistent status");

endmodule

bind buffered_uart_fifo_engine_core bufe_chk u_bufe_chk (.*);
